>>> rtl/sorted_key_equal_range_search_top_defines.svh
// ---------------------------------------------------------------------------
// Sorted key equal range search: assertion macros
// Shared concurrent assertion forms for the search block.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_EQUAL_RANGE_SEARCH_TOP_DEFINES_SVH
`define SORTED_KEY_EQUAL_RANGE_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SKEQR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SKEQR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/skeqr_pkg.sv
// ---------------------------------------------------------------------------
// Sorted key equal range search: package
// Field widths, opcodes and sequencer state codes.
// ---------------------------------------------------------------------------
package skeqr_pkg;

   // item field widths
   localparam int KEY_W   = 32;
   localparam int SLOT_W  = 10;
   localparam int COUNT_W = 11;

   // item opcodes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // sequencer states, one-hot
   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_PROBE_RD = 8'b0000_0010,
      ST_PROBE_CK = 8'b0000_0100,
      ST_DOWN_RD  = 8'b0000_1000,
      ST_DOWN_CK  = 8'b0001_0000,
      ST_UP_RD    = 8'b0010_0000,
      ST_UP_CK    = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

endpackage

>>> rtl/skeqr_req_if.sv
// ---------------------------------------------------------------------------
// Sorted key equal range search: request channel
// Valid/ready channel carrying write and search items.
// ---------------------------------------------------------------------------
interface skeqr_req_if import skeqr_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic [SLOT_W-1:0]       slot;
   logic signed [KEY_W-1:0] key;

   modport source (output valid, output opcode, output slot, output key, input ready);
   modport sink   (input valid, input opcode, input slot, input key, output ready);

endinterface

>>> rtl/skeqr_rsp_if.sv
// ---------------------------------------------------------------------------
// Sorted key equal range search: result channel
// Valid/ready channel carrying one result item per search.
// ---------------------------------------------------------------------------
interface skeqr_rsp_if import skeqr_pkg::*; ();

   logic               valid;
   logic               ready;
   logic               found;
   logic [COUNT_W-1:0] first_index;
   logic [COUNT_W-1:0] end_index;

   modport source (output valid, output found, output first_index, output end_index,
                   input ready);
   modport sink   (input valid, input found, input first_index, input end_index,
                   output ready);

endinterface

>>> rtl/sorted_key_equal_range_search_top.sv
// ---------------------------------------------------------------------------
// Sorted key equal range search
// Holds a table of signed 32-bit keys in one synchronous memory, loaded by
// write items and meant to be sorted ascending; csr_wdata sets how many
// entries are in use (clamped to TABLE_DEPTH). A search item runs a binary
// probe over the entries in use and, on a hit, walks down and up from the
// hit over equal keys, returning found plus the first index and one past
// the last index of the run (both zero when the key is absent). Every table
// access is a read of the single read port, registered, then a compare,
// so each probe and each step of the walk takes a read state and then a
// check state. A write item with a slot inside the table is written when
// it is accepted. A search makes at most log2(entries)+2 probes with these
// bound rules, 12 for a 1024-entry table, and its walk examines the
// duplicates plus at most one mismatching neighbor on each side. One
// search is worked on at a time; the finished result sits in an output
// register so that the next item can be taken while it waits. The table
// has no reset; a search must only touch entries already written.
// ---------------------------------------------------------------------------
`include "sorted_key_equal_range_search_top_defines.svh"

module sorted_key_equal_range_search_top
   import skeqr_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata,
   skeqr_req_if.sink          req_ch,
   skeqr_rsp_if.source        rsp_ch
);

   localparam int          IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int          CNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam logic [31:0] DEPTH_32 = TABLE_DEPTH;

   // key table
   logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
   logic signed [KEY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    mem_we;

   // control and working registers
   state_type               state_ff, state_in;
   logic [COUNT_W-1:0]      entry_count_ff;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hb_ff, hb_in;
   logic [IDX_W-1:0]        mid_ff, mid_in;
   logic [CNT_W-1:0]        first_ff, first_in;
   logic [CNT_W-1:0]        end_ff, end_in;
   logic                    found_ff, found_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff;
   logic [COUNT_W-1:0]      rsp_first_ff;
   logic [COUNT_W-1:0]      rsp_end_ff;
   logic                    rsp_load;

   logic                    req_accept;
   logic [CNT_W-1:0]        entries;
   logic [CNT_W:0]          mid_sum;
   logic [CNT_W-1:0]        mid_ext;
   logic [CNT_W-1:0]        lo_next;
   logic [CNT_W-1:0]        hb_next;
   logic                    slot_ok;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid & req_ch.ready;

   // entries in use, clamped to the table depth
   assign entries = (32'(entry_count_ff) > DEPTH_32) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(entry_count_ff);

   // probe midpoint of the window lo .. hb-1
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hb_ff} - (CNT_W + 1)'(1);
   assign mid_ext = CNT_W'(mid_ff);

   assign slot_ok = (32'(req_ch.slot) < DEPTH_32);
   assign mem_we  = req_accept & (req_ch.opcode == OP_WRITE) & slot_ok;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_we) begin
         entry_count_ff <= csr_wdata;
      end
   end

   // table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[IDX_W'(req_ch.slot)] <= req_ch.key;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   // bound updates after a probe miss
   always_comb begin
      lo_next = lo_ff;
      hb_next = hb_ff;
      if (key_ff < rd_data_ff) begin
         hb_next = (mid_ext + CNT_W'(1) == hb_ff) ? mid_ext : mid_ext + CNT_W'(1);
      end else begin
         lo_next = (mid_ext == lo_ff) ? lo_ff + CNT_W'(1) : mid_ext;
      end
   end

   // search sequencer
   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      lo_in    = lo_ff;
      hb_in    = hb_ff;
      mid_in   = mid_ff;
      first_in = first_ff;
      end_in   = end_ff;
      found_in = found_ff;
      rd_addr  = mid_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_ch.opcode == OP_SEARCH)) begin
               key_in   = req_ch.key;
               lo_in    = '0;
               hb_in    = entries;
               found_in = 1'b0;
               first_in = '0;
               end_in   = '0;
               state_in = (entries == '0) ? ST_DONE : ST_PROBE_RD;
            end
         end
         ST_PROBE_RD: begin
            mid_in   = IDX_W'(mid_sum >> 1);
            rd_addr  = IDX_W'(mid_sum >> 1);
            state_in = ST_PROBE_CK;
         end
         ST_PROBE_CK: begin
            if (rd_data_ff == key_ff) begin
               found_in = 1'b1;
               first_in = mid_ext;
               end_in   = mid_ext + CNT_W'(1);
               state_in = ST_DOWN_RD;
            end else begin
               lo_in    = lo_next;
               hb_in    = hb_next;
               state_in = (lo_next < hb_next) ? ST_PROBE_RD : ST_DONE;
            end
         end
         ST_DOWN_RD: begin
            rd_addr  = IDX_W'(first_ff - CNT_W'(1));
            state_in = (first_ff == '0) ? ST_UP_RD : ST_DOWN_CK;
         end
         ST_DOWN_CK: begin
            if (rd_data_ff == key_ff) begin
               first_in = first_ff - CNT_W'(1);
               state_in = ST_DOWN_RD;
            end else begin
               state_in = ST_UP_RD;
            end
         end
         ST_UP_RD: begin
            rd_addr  = IDX_W'(end_ff);
            state_in = (end_ff >= entries) ? ST_DONE : ST_UP_CK;
         end
         ST_UP_CK: begin
            if (rd_data_ff == key_ff) begin
               end_in   = end_ff + CNT_W'(1);
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff   <= key_in;
      lo_ff    <= lo_in;
      hb_ff    <= hb_in;
      mid_ff   <= mid_in;
      first_ff <= first_in;
      end_ff   <= end_in;
      found_ff <= found_in;
   end

   // result register
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_first_ff <= COUNT_W'(first_ff);
         rsp_end_ff   <= COUNT_W'(end_ff);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.first_index = rsp_first_ff;
   assign rsp_ch.end_index   = rsp_end_ff;

   // a miss reports zero bounds
   `SKEQR_ASSERT_NOW(a_miss_zero, clock, reset,
      (state_ff == ST_DONE) && !found_ff,
      (first_ff == '0) && (end_ff == '0), "miss with nonzero bounds")

   // a hit reports a nonempty range inside the entries in use
   `SKEQR_ASSERT_NOW(a_hit_range, clock, reset,
      (state_ff == ST_DONE) && found_ff,
      (first_ff < end_ff) && (end_ff <= entries), "hit with bad range")

   // a probe is only issued on a nonempty window within the table
   `SKEQR_ASSERT_NOW(a_probe_window, clock, reset,
      state_ff == ST_PROBE_RD,
      (lo_ff < hb_ff) && (hb_ff <= entries), "probe on empty window")

   // an accepted search always leaves idle
   `SKEQR_ASSERT_NEXT(a_search_busy, clock, reset,
      req_accept && (req_ch.opcode == OP_SEARCH),
      state_ff != ST_IDLE, "search not started")

endmodule
